@@ design/dshot_frame_encoder_macros.svh @@
// Assertion macros used by the DShot frame encoder checker.
`ifndef DSHOT_FRAME_ENCODER_MACROS_SVH
`define DSHOT_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dshot_frame_encoder check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dshot_frame_encoder check failed");

`endif

@@ design/dfe_pkg.sv @@
// Types, constants and arithmetic helpers of the DShot frame encoder.
package dfe_pkg;

  localparam int unsigned PwW       = 12;
  localparam int unsigned CodeW     = 11;
  localparam int unsigned TicksW    = 8;
  localparam int unsigned FrameBits = 16;
  localparam int unsigned CrcW      = 4;
  localparam int unsigned SlotW     = $clog2(FrameBits + 1);
  localparam int unsigned BitIdxW   = $clog2(FrameBits);
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [PwW-1:0]    PwMinUs     = PwW'(1000);
  localparam logic [PwW-1:0]    PwMaxUs     = PwW'(2000);
  localparam logic [PwW-1:0]    HalfSpan    = PwW'(500);
  localparam logic [CodeW-1:0]  CodeOffset  = CodeW'(48);
  localparam logic [TicksW-1:0] OneReset    = TicksW'(180);
  localparam logic [TicksW-1:0] ZeroReset   = TicksW'(90);
  localparam logic [TicksW-1:0] IdleTicks   = '0;
  localparam logic [SlotW-1:0]  SlotIdle    = SlotW'(FrameBits);

  localparam logic [CfgIdxW-1:0] CfgOnePulse  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgZeroPulse = CfgIdxW'(1);

  typedef struct packed {
    logic [PwW-1:0] pulse_width_us;
    logic           telemetry_request;
  } in_t;

  typedef struct packed {
    logic [TicksW-1:0] pulse_ticks;
    logic [CodeW-1:0]  throttle_code;
    logic              last_slot;
  } out_t;

  typedef struct packed {
    logic [FrameBits-1:0] bits;
    logic [CodeW-1:0]     code;
  } frame_t;

  // (d*1999 + 500) / 1000 equals 2d for d <= 500 and 2d - 1 above, d in 0..1000.
  function automatic logic [CodeW-1:0] width_to_code(input logic [PwW-1:0] p);
    logic [PwW-1:0] d;
    logic [PwW:0]   q;
    d = p - PwMinUs;
    q = {d, 1'b0} - ((d > HalfSpan) ? (PwW+1)'(1) : '0);
    return CodeOffset + q[CodeW-1:0];
  endfunction

  function automatic logic [CrcW-1:0] frame_crc(input logic [CodeW:0] word);
    return word[11:8] ^ word[7:4] ^ word[3:0];
  endfunction

endpackage

@@ design/dfe_front.sv @@
// Front end: clamps the pulse width, builds the throttle code and the 16-bit frame.
module dfe_front (
  input  dfe_pkg::in_t    item_i,
  output dfe_pkg::frame_t frame_o
);
  import dfe_pkg::*;

  logic [PwW-1:0]   pw;
  logic             arm;
  logic [CodeW-1:0] code;
  logic [CodeW:0]   word;

  always_comb begin
    pw   = item_i.pulse_width_us;
    arm  = (pw <= PwMinUs);
    if (pw > PwMaxUs) begin
      pw = PwMaxUs;
    end
    code = width_to_code(pw);
    word = {code, item_i.telemetry_request};
    if (arm) begin
      frame_o.bits = '0;
      frame_o.code = '0;
    end else begin
      frame_o.bits = {word, frame_crc(word)};
      frame_o.code = code;
    end
  end

endmodule

@@ design/dfe_queue.sv @@
// Short frame queue between the front end and the serializer.
module dfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  dfe_pkg::frame_t wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output dfe_pkg::frame_t rd_data_o,
  output logic            valid_o
);
  import dfe_pkg::*;

  frame_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              wr_en, rd_en;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/dfe_back.sv @@
// Serializer: walks the head frame slot by slot into the result register.
module dfe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  dfe_pkg::frame_t             q_data_i,
  output logic                        q_rd_o,
  input  logic [dfe_pkg::TicksW-1:0]  one_ticks_i,
  input  logic [dfe_pkg::TicksW-1:0]  zero_ticks_i,
  output logic                        empty,
  input  logic                        pop,
  output dfe_pkg::out_t               result_o
);
  import dfe_pkg::*;

  logic [SlotW-1:0]   slot_q, slot_d;
  logic               vld_q, vld_d;
  out_t               res_q, res_d;
  logic               load, take, at_idle;
  logic [BitIdxW-1:0] bit_idx;

  assign load     = !vld_q || pop;
  assign take     = load && q_valid_i;
  assign at_idle  = (slot_q == SlotIdle);
  assign bit_idx  = BitIdxW'(FrameBits - 1) - slot_q[BitIdxW-1:0];
  assign q_rd_o   = take && at_idle;
  assign empty    = !vld_q;
  assign result_o = res_q;

  always_comb begin
    slot_d = slot_q;
    vld_d  = vld_q;
    res_d  = res_q;
    if (load) begin
      vld_d = q_valid_i;
    end
    if (take) begin
      res_d.throttle_code = q_data_i.code;
      res_d.last_slot     = at_idle;
      if (at_idle) begin
        res_d.pulse_ticks = IdleTicks;
        slot_d            = '0;
      end else begin
        res_d.pulse_ticks = q_data_i.bits[bit_idx] ? one_ticks_i : zero_ticks_i;
        slot_d            = slot_q + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      slot_q <= slot_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

@@ design/dshot_frame_encoder.sv @@
// Top level of the DShot frame encoder: config registers, front end, queue, serializer.
// With the serializer idle, an input word is queued, then its first result word goes to the result register.
// Throughput: 17 result words per input word, one per cycle while pop is held; the serializer sets the rate.
// A two-entry frame queue lets new input words in while a frame is still being sent.
// Reset: queue and result register empty; one_pulse_ticks 180, zero_pulse_ticks 90.
module dshot_frame_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  dfe_pkg::in_t                 item_i,
  output logic                         empty,
  input  logic                         pop,
  output dfe_pkg::out_t                result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dfe_pkg::TicksW-1:0]   cfg_data_i
);
  import dfe_pkg::*;

  logic [TicksW-1:0] one_q, one_d;
  logic [TicksW-1:0] zero_q, zero_d;
  frame_t            front_frame, head_frame;
  logic              q_valid, q_rd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    one_d  = one_q;
    zero_d = zero_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOnePulse:  one_d  = cfg_data_i;
        CfgZeroPulse: zero_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_q  <= OneReset;
      zero_q <= ZeroReset;
    end else begin
      one_q  <= one_d;
      zero_q <= zero_d;
    end
  end

  dfe_front u_front (
    .item_i  (item_i),
    .frame_o (front_frame)
  );

  dfe_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (front_frame),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (head_frame),
    .valid_o   (q_valid)
  );

  dfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (head_frame),
    .q_rd_o       (q_rd),
    .one_ticks_i  (one_q),
    .zero_ticks_i (zero_q),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule

@@ design/dfe_checker.sv @@
// Port-level checker for the DShot frame encoder, bound to the top level.
`include "dshot_frame_encoder_macros.svh"

module dfe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input dfe_pkg::out_t  result_o
);
  import dfe_pkg::*;

  logic mid_pop;

  assign mid_pop = !empty && pop && !result_o.last_slot;

  `DFE_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(result_o))
  `DFE_ASSERT_NOW(a_idle_zero, !empty && result_o.last_slot, result_o.pulse_ticks == IdleTicks)
  `DFE_ASSERT_NEXT(a_code_steady, mid_pop, empty || $stable(result_o.throttle_code))

endmodule

bind dshot_frame_encoder dfe_checker u_dfe_checker (.*);
